@@ hdl/gbf_pkg.sv @@
package gbf_pkg;

  localparam int unsigned DIM_MAX_DEF      = 16;
  localparam int unsigned MAX_VERTICES_DEF = 4096;
  localparam int unsigned MAX_EDGES_DEF    = 16384;
  localparam int unsigned CMDQ_DEPTH       = 4;

  localparam int unsigned DIST_W     = 48;
  localparam int unsigned WEIGHT_W   = 32;
  localparam int unsigned RAWIDX_W   = 15;
  localparam int unsigned PASSOUT_W  = 12;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 5;

  localparam logic [DIST_W-1:0] DIST_MAX = {1'b0, {(DIST_W-1){1'b1}}};
  localparam logic [DIST_W-1:0] DIST_MIN = {1'b1, {(DIST_W-1){1'b0}}};

  localparam logic [1:0] REQ_LOAD  = 2'd0;
  localparam logic [1:0] REQ_RUN   = 2'd1;
  localparam logic [1:0] REQ_QUERY = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_X   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Y   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Z   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE_3D  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Z = 3'd6;

  localparam logic RK_RUN   = 1'b0;
  localparam logic RK_QUERY = 1'b1;

  typedef enum logic [1:0] {
    CMD_LOAD,
    CMD_RUN,
    CMD_QUERY
  } cmd_e;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_QRD,
    S_QWAIT,
    S_RCLR,
    S_RSRC,
    S_RPASS,
    S_REDGE,
    S_REWAIT,
    S_RVWAIT,
    S_RADD,
    S_RDONE
  } state_e;

  typedef struct packed {
    logic [4:0] size_x;
    logic [4:0] size_y;
    logic [4:0] size_z;
    logic       mode_3d;
    logic [3:0] origin_x;
    logic [3:0] origin_y;
    logic [3:0] origin_z;
  } cfg_t;

  typedef struct packed {
    logic                ok;
    logic [RAWIDX_W-1:0] idx;
  } vidx_t;

  typedef struct packed {
    logic                  kind;
    logic [31:0]           relax_count;
    logic [PASSOUT_W-1:0]  passes_used;
    logic                  edges_dropped;
    logic                  reachable;
    logic [DIST_W-1:0]     distance;
  } res_t;

  function automatic logic [4:0] extent_f(logic [4:0] v, logic [6:0] dmax);
    logic [4:0] e;
    if (v == 5'd0) begin
      e = 5'd1;
    end else if ({2'b00, v} > dmax) begin
      e = dmax[4:0];
    end else begin
      e = v;
    end
    return e;
  endfunction

  // Linear vertex index x + sx*(y + sy*z) under the effective extents.
  function automatic vidx_t vidx_f(logic [3:0] x, logic [3:0] y, logic [3:0] z,
                                   cfg_t c, logic [6:0] dmax);
    logic [4:0]  ex;
    logic [4:0]  ey;
    logic [4:0]  ez;
    logic [3:0]  zz;
    logic [9:0]  yz;
    vidx_t       r;
    ex = extent_f(c.size_x, dmax);
    ey = extent_f(c.size_y, dmax);
    ez = c.mode_3d ? extent_f(c.size_z, dmax) : 5'd1;
    zz = c.mode_3d ? z : 4'd0;
    r.ok = ({1'b0, x} < ex) && ({1'b0, y} < ey) && ({1'b0, zz} < ez);
    yz = 10'(y) + 10'(ey) * 10'(zz);
    r.idx = RAWIDX_W'(x) + RAWIDX_W'(ex) * RAWIDX_W'(yz);
    return r;
  endfunction

endpackage

@@ hdl/gbf_ram.sv @@
module gbf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem[raddr_a_i];
    rdata_b_o <= mem[raddr_b_i];
  end

endmodule

@@ hdl/gbf_fifo.sv @@
module gbf_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);

  localparam int unsigned AW = $clog2(DEPTH);

  logic [WIDTH-1:0] slot_q [DEPTH];
  logic [AW-1:0]    wptr_q, wptr_d, rptr_q, rptr_d;
  logic [AW:0]      cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == (AW+1)'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = slot_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == AW'(DEPTH-1)) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == AW'(DEPTH-1)) ? '0 : rptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wptr_q] <= wdata_i;
    end
  end

endmodule

@@ hdl/gbf_front.sv @@
module gbf_front
  import gbf_pkg::*;
#(
  parameter int unsigned DIM_MAX      = DIM_MAX_DEF,
  parameter int unsigned MAX_VERTICES = MAX_VERTICES_DEF,
  parameter int unsigned VIDX_W       = $clog2(MAX_VERTICES),
  parameter int unsigned CMD_W        = 3 + 2*VIDX_W + WEIGHT_W
) (
  input  cfg_t               cfg_i,
  input  logic               accept_i,
  input  logic [1:0]         req_type_i,
  input  logic [3:0]         from_x_i,
  input  logic [3:0]         from_y_i,
  input  logic [3:0]         from_z_i,
  input  logic [3:0]         to_x_i,
  input  logic [3:0]         to_y_i,
  input  logic [3:0]         to_z_i,
  input  logic [WEIGHT_W-1:0] edge_weight_i,
  output logic               cmd_push_o,
  output logic [CMD_W-1:0]   cmd_o
);

  vidx_t       va, vb;
  logic [31:0] a32, b32;
  logic        a_ok, b_ok;
  cmd_e        kind;
  logic        ok;

  always_comb begin
    va   = vidx_f(from_x_i, from_y_i, from_z_i, cfg_i, 7'(DIM_MAX));
    vb   = vidx_f(to_x_i, to_y_i, to_z_i, cfg_i, 7'(DIM_MAX));
    a32  = 32'(va.idx);
    b32  = 32'(vb.idx);
    a_ok = va.ok && (a32 < 32'(MAX_VERTICES));
    b_ok = vb.ok && (b32 < 32'(MAX_VERTICES));
    kind = CMD_LOAD;
    ok   = 1'b0;
    cmd_push_o = 1'b0;
    case (req_type_i)
      REQ_LOAD: begin
        kind = CMD_LOAD;
        ok   = a_ok && b_ok;
        cmd_push_o = accept_i;
      end
      REQ_RUN: begin
        kind = CMD_RUN;
        cmd_push_o = accept_i;
      end
      REQ_QUERY: begin
        kind = CMD_QUERY;
        ok   = a_ok;
        cmd_push_o = accept_i;
      end
      default: begin
        // Reserved request type: accepted and dropped here.
        cmd_push_o = 1'b0;
      end
    endcase
    cmd_o = {kind, ok, a32[VIDX_W-1:0], b32[VIDX_W-1:0], edge_weight_i};
  end

endmodule

@@ hdl/gbf_back.sv @@
module gbf_back
  import gbf_pkg::*;
#(
  parameter int unsigned DIM_MAX      = DIM_MAX_DEF,
  parameter int unsigned MAX_VERTICES = MAX_VERTICES_DEF,
  parameter int unsigned MAX_EDGES    = MAX_EDGES_DEF,
  parameter int unsigned VIDX_W       = $clog2(MAX_VERTICES),
  parameter int unsigned CMD_W        = 3 + 2*VIDX_W + WEIGHT_W
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cfg_t             cfg_i,
  input  logic [CMD_W-1:0] cmd_i,
  input  logic             cmd_empty_i,
  output logic             cmd_pop_o,
  output logic             ready_o,
  output res_t             res_o,
  output logic             res_valid_o,
  input  logic             res_pop_i
);

  localparam int unsigned EIDX_W = $clog2(MAX_EDGES);
  localparam int unsigned ECNT_W = $clog2(MAX_EDGES + 1);
  localparam int unsigned VCNT_W = $clog2(MAX_VERTICES + 1);
  localparam int unsigned EDGE_W = 2*VIDX_W + WEIGHT_W;
  localparam int unsigned DW     = DIST_W + 1;

  state_e state_q, state_d;

  logic [1:0]           c_kind_bits;
  cmd_e                 c_kind;
  logic                 c_ok;
  logic [VIDX_W-1:0]    c_a, c_b;
  logic [WEIGHT_W-1:0]  c_w;

  logic [ECNT_W-1:0] ecnt_q, ecnt_d;
  logic [ECNT_W-1:0] j_q, j_d;
  logic              drop_q, drop_d;
  logic [31:0]       last_relax_q, last_relax_d;
  logic [31:0]       relax_q, relax_d;
  logic [VCNT_W-1:0] pass_q, pass_d, plim_q, plim_d;
  logic              changed_q, changed_d;
  logic [VIDX_W-1:0] clr_q, clr_d;
  logic [VIDX_W-1:0] qidx_q, qidx_d;
  logic              qok_q, qok_d;
  logic [VIDX_W-1:0] head_q, head_d;
  logic [WEIGHT_W-1:0] w_q, w_d;
  logic [DIST_W:0]   sum_q, sum_d;
  logic              hreach_q, hreach_d;
  logic [DIST_W-1:0] hdist_q, hdist_d;
  res_t              res_q, res_d;
  logic              rvalid_q, rvalid_d;

  logic                e_we;
  logic [EDGE_W-1:0]   e_rdata;
  logic [VIDX_W-1:0]   e_tail, e_head;
  logic [WEIGHT_W-1:0] e_w;
  logic                d_we;
  logic [VIDX_W-1:0]   d_waddr, d_raddr_a;
  logic [DW-1:0]       d_wdata, d_rdata_a, d_rdata_b;

  logic              out_free;
  vidx_t             src;
  logic [31:0]       src32;
  logic              src_ok;
  logic [9:0]        vxy;
  logic [RAWIDX_W-1:0] vprod;
  logic [31:0]       vlim;
  logic [DIST_W-1:0] nd;
  logic              relax_hit;

  assign {c_kind_bits, c_ok, c_a, c_b, c_w} = cmd_i;
  assign c_kind = cmd_e'(c_kind_bits);
  assign {e_tail, e_head, e_w} = e_rdata;
  assign out_free    = !rvalid_q || res_pop_i;
  assign res_o       = res_q;
  assign res_valid_o = rvalid_q;
  assign ready_o     = (state_q != S_INIT);

  always_comb begin
    src   = vidx_f(cfg_i.origin_x, cfg_i.origin_y, cfg_i.origin_z, cfg_i, 7'(DIM_MAX));
    src32 = 32'(src.idx);
    src_ok = src.ok && (src32 < 32'(MAX_VERTICES));
    vxy   = 10'(extent_f(cfg_i.size_x, 7'(DIM_MAX))) *
            10'(extent_f(cfg_i.size_y, 7'(DIM_MAX)));
    vprod = RAWIDX_W'(vxy) * RAWIDX_W'(cfg_i.mode_3d ?
            extent_f(cfg_i.size_z, 7'(DIM_MAX)) : 5'd1);
    vlim  = (32'(vprod) > 32'(MAX_VERTICES)) ? 32'(MAX_VERTICES) : 32'(vprod);
    // Saturate the widened sum back into the signed distance range.
    if (sum_q[DIST_W] != sum_q[DIST_W-1]) begin
      nd = sum_q[DIST_W] ? DIST_MIN : DIST_MAX;
    end else begin
      nd = sum_q[DIST_W-1:0];
    end
    relax_hit = !hreach_q || ($signed(nd) < $signed(hdist_q));
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_INIT: begin
        if (clr_q == VIDX_W'(MAX_VERTICES - 1)) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (!cmd_empty_i) begin
          case (c_kind)
            CMD_RUN:   state_d = S_RCLR;
            CMD_QUERY: state_d = S_QRD;
            default:   state_d = S_IDLE;
          endcase
        end
      end
      S_QRD: state_d = S_QWAIT;
      S_QWAIT: begin
        if (out_free) state_d = S_IDLE;
      end
      S_RCLR: begin
        if (clr_q == VIDX_W'(MAX_VERTICES - 1)) state_d = S_RSRC;
      end
      S_RSRC: state_d = S_RPASS;
      S_RPASS: begin
        state_d = (pass_q == plim_q || !changed_q) ? S_RDONE : S_REDGE;
      end
      S_REDGE: begin
        state_d = (j_q == ecnt_q) ? S_RPASS : S_REWAIT;
      end
      S_REWAIT: state_d = S_RVWAIT;
      S_RVWAIT: begin
        state_d = d_rdata_a[DIST_W] ? S_RADD : S_REDGE;
      end
      S_RADD: state_d = S_REDGE;
      S_RDONE: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath and memory controls.
  always_comb begin
    ecnt_d       = ecnt_q;
    j_d          = j_q;
    drop_d       = drop_q;
    last_relax_d = last_relax_q;
    relax_d      = relax_q;
    pass_d       = pass_q;
    plim_d       = plim_q;
    changed_d    = changed_q;
    clr_d        = clr_q;
    qidx_d       = qidx_q;
    qok_d        = qok_q;
    head_d       = head_q;
    w_d          = w_q;
    sum_d        = sum_q;
    hreach_d     = hreach_q;
    hdist_d      = hdist_q;
    res_d        = res_q;
    rvalid_d     = rvalid_q && !res_pop_i;
    cmd_pop_o    = 1'b0;
    e_we         = 1'b0;
    d_we         = 1'b0;
    d_waddr      = clr_q;
    d_wdata      = '0;
    d_raddr_a    = (state_q == S_REWAIT) ? e_tail : qidx_q;
    case (state_q)
      S_INIT: begin
        d_we  = 1'b1;
        clr_d = clr_q + 1'b1;
      end
      S_IDLE: begin
        if (!cmd_empty_i) begin
          cmd_pop_o = 1'b1;
          case (c_kind)
            CMD_LOAD: begin
              if (c_ok && ecnt_q < ECNT_W'(MAX_EDGES)) begin
                e_we   = 1'b1;
                ecnt_d = ecnt_q + 1'b1;
              end else begin
                drop_d = 1'b1;
              end
            end
            CMD_RUN: begin
              clr_d     = '0;
              pass_d    = '0;
              relax_d   = '0;
              changed_d = 1'b1;
              plim_d    = VCNT_W'(vlim - 32'd1);
            end
            CMD_QUERY: begin
              qidx_d = c_a;
              qok_d  = c_ok;
            end
            default: ;
          endcase
        end
      end
      S_QWAIT: begin
        if (out_free) begin
          rvalid_d            = 1'b1;
          res_d.kind          = RK_QUERY;
          res_d.relax_count   = last_relax_q;
          res_d.passes_used   = '0;
          res_d.edges_dropped = drop_q;
          res_d.reachable     = qok_q && d_rdata_a[DIST_W];
          res_d.distance      = (qok_q && d_rdata_a[DIST_W]) ? d_rdata_a[DIST_W-1:0] : '0;
        end
      end
      S_RCLR: begin
        d_we  = 1'b1;
        clr_d = clr_q + 1'b1;
      end
      S_RSRC: begin
        d_we    = src_ok;
        d_waddr = src32[VIDX_W-1:0];
        d_wdata = {1'b1, {DIST_W{1'b0}}};
      end
      S_RPASS: begin
        if (pass_q != plim_q && changed_q) begin
          pass_d    = pass_q + 1'b1;
          changed_d = 1'b0;
          j_d       = '0;
        end
      end
      S_REWAIT: begin
        head_d = e_head;
        w_d    = e_w;
      end
      S_RVWAIT: begin
        if (d_rdata_a[DIST_W]) begin
          sum_d    = {d_rdata_a[DIST_W-1], d_rdata_a[DIST_W-1:0]} +
                     {{(DIST_W+1-WEIGHT_W){w_q[WEIGHT_W-1]}}, w_q};
          hreach_d = d_rdata_b[DIST_W];
          hdist_d  = d_rdata_b[DIST_W-1:0];
        end else begin
          j_d = j_q + 1'b1;
        end
      end
      S_RADD: begin
        j_d = j_q + 1'b1;
        if (relax_hit) begin
          d_we      = 1'b1;
          d_waddr   = head_q;
          d_wdata   = {1'b1, nd};
          changed_d = 1'b1;
          if (relax_q != '1) relax_d = relax_q + 1'b1;
        end
      end
      S_RDONE: begin
        if (out_free) begin
          rvalid_d            = 1'b1;
          res_d.kind          = RK_RUN;
          res_d.relax_count   = relax_q;
          res_d.passes_used   = (32'(pass_q) > 32'd4095) ? '1 : PASSOUT_W'(32'(pass_q));
          res_d.edges_dropped = drop_q;
          res_d.reachable     = 1'b0;
          res_d.distance      = '0;
          last_relax_d        = relax_q;
          ecnt_d              = '0;
          drop_d              = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_INIT;
      ecnt_q       <= '0;
      drop_q       <= 1'b0;
      last_relax_q <= '0;
      clr_q        <= '0;
      rvalid_q     <= 1'b0;
    end else begin
      state_q      <= state_d;
      ecnt_q       <= ecnt_d;
      drop_q       <= drop_d;
      last_relax_q <= last_relax_d;
      clr_q        <= clr_d;
      rvalid_q     <= rvalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    j_q       <= j_d;
    relax_q   <= relax_d;
    pass_q    <= pass_d;
    plim_q    <= plim_d;
    changed_q <= changed_d;
    qidx_q    <= qidx_d;
    qok_q     <= qok_d;
    head_q    <= head_d;
    w_q       <= w_d;
    sum_q     <= sum_d;
    hreach_q  <= hreach_d;
    hdist_q   <= hdist_d;
    res_q     <= res_d;
  end

  gbf_ram #(.WIDTH(EDGE_W), .DEPTH(MAX_EDGES)) u_edge_ram (
    .clk_i     (clk_i),
    .we_i      (e_we),
    .waddr_i   (ecnt_q[EIDX_W-1:0]),
    .wdata_i   ({c_a, c_b, c_w}),
    .raddr_a_i (j_q[EIDX_W-1:0]),
    .rdata_a_o (e_rdata),
    .raddr_b_i (j_q[EIDX_W-1:0]),
    .rdata_b_o ()
  );

  // Top bit of each entry is the reach flag; the rest is the distance.
  gbf_ram #(.WIDTH(DW), .DEPTH(MAX_VERTICES)) u_dist_ram (
    .clk_i     (clk_i),
    .we_i      (d_we),
    .waddr_i   (d_waddr),
    .wdata_i   (d_wdata),
    .raddr_a_i (d_raddr_a),
    .rdata_a_o (d_rdata_a),
    .raddr_b_i (e_head),
    .rdata_b_o (d_rdata_b)
  );

  a_ecnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ecnt_q <= ECNT_W'(MAX_EDGES))
    else $error("edge count exceeds store depth");

  a_run_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RDONE && out_free) |=> (ecnt_q == '0 && !drop_q && rvalid_q))
    else $error("run end did not empty the edge store");

  a_dist_write_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    d_we |-> (state_q == S_INIT || state_q == S_RCLR || state_q == S_RSRC ||
              state_q == S_RADD))
    else $error("distance memory written outside a run or init sweep");

  a_no_pop_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_o |-> (state_q == S_IDLE))
    else $error("command taken while busy");

endmodule

@@ hdl/grid_bellman_ford_shortest_paths.sv @@
// Grid Bellman-Ford engine. Edge load requests are taken one per cycle while
// full is low into a four-entry command queue and retired by the back end
// from its idle state; a query passes a read state and a wait state held until
// the result register is free. A run request first sweeps the distance memory,
// then makes up to V-1 passes; each pass has a pass check and an end-of-list
// check plus, per stored edge, an edge read, a tail-distance wait and, if the
// tail is reachable, an add step, on the single shared read-modify-write path
// through the distance memory. After reset the block sweeps the distance memory
// and holds full high meanwhile; configuration writes are taken at any time.
module grid_bellman_ford_shortest_paths
  import gbf_pkg::*;
#(
  parameter int unsigned DIM_MAX      = DIM_MAX_DEF,
  parameter int unsigned MAX_VERTICES = MAX_VERTICES_DEF,
  parameter int unsigned MAX_EDGES    = MAX_EDGES_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  push,
  output logic                  full,
  input  logic [1:0]            req_type_i,
  input  logic [3:0]            from_x_i,
  input  logic [3:0]            from_y_i,
  input  logic [3:0]            from_z_i,
  input  logic [3:0]            to_x_i,
  input  logic [3:0]            to_y_i,
  input  logic [3:0]            to_z_i,
  input  logic signed [31:0]    edge_weight_i,
  output logic                  empty,
  input  logic                  pop,
  output logic                  result_kind_o,
  output logic [31:0]           relax_count_o,
  output logic [11:0]           passes_used_o,
  output logic                  edges_dropped_o,
  output logic                  reachable_o,
  output logic signed [47:0]    distance_o
);

  localparam int unsigned VIDX_W = $clog2(MAX_VERTICES);
  localparam int unsigned CMD_W  = 3 + 2*VIDX_W + WEIGHT_W;

  cfg_t             cfg_q, cfg_d;
  logic             q_full, q_empty, q_push, q_pop, back_ready;
  logic [CMD_W-1:0] q_wdata, q_rdata;
  res_t             res;
  logic             res_valid;

  assign cfg_ready_o = 1'b1;
  assign full        = q_full || !back_ready;
  assign empty       = !res_valid;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_SIZE_X:   cfg_d.size_x   = cfg_data_i;
        CFG_SIZE_Y:   cfg_d.size_y   = cfg_data_i;
        CFG_SIZE_Z:   cfg_d.size_z   = cfg_data_i;
        CFG_MODE_3D:  cfg_d.mode_3d  = cfg_data_i[0];
        CFG_ORIGIN_X: cfg_d.origin_x = cfg_data_i[3:0];
        CFG_ORIGIN_Y: cfg_d.origin_y = cfg_data_i[3:0];
        CFG_ORIGIN_Z: cfg_d.origin_z = cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{size_x: 5'd16, size_y: 5'd16, size_z: 5'd1, mode_3d: 1'b0,
                 origin_x: 4'd0, origin_y: 4'd0, origin_z: 4'd0};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  gbf_front #(
    .DIM_MAX(DIM_MAX), .MAX_VERTICES(MAX_VERTICES), .VIDX_W(VIDX_W), .CMD_W(CMD_W)
  ) u_front (
    .cfg_i         (cfg_q),
    .accept_i      (push && !full),
    .req_type_i    (req_type_i),
    .from_x_i      (from_x_i),
    .from_y_i      (from_y_i),
    .from_z_i      (from_z_i),
    .to_x_i        (to_x_i),
    .to_y_i        (to_y_i),
    .to_z_i        (to_z_i),
    .edge_weight_i (edge_weight_i),
    .cmd_push_o    (q_push),
    .cmd_o         (q_wdata)
  );

  gbf_fifo #(.WIDTH(CMD_W), .DEPTH(CMDQ_DEPTH)) u_cmdq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .wdata_i (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .rdata_o (q_rdata),
    .empty_o (q_empty)
  );

  gbf_back #(
    .DIM_MAX(DIM_MAX), .MAX_VERTICES(MAX_VERTICES), .MAX_EDGES(MAX_EDGES),
    .VIDX_W(VIDX_W), .CMD_W(CMD_W)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_i       (q_rdata),
    .cmd_empty_i (q_empty),
    .cmd_pop_o   (q_pop),
    .ready_o     (back_ready),
    .res_o       (res),
    .res_valid_o (res_valid),
    .res_pop_i   (pop)
  );

  assign result_kind_o   = res.kind;
  assign relax_count_o   = res.relax_count;
  assign passes_used_o   = res.passes_used;
  assign edges_dropped_o = res.edges_dropped;
  assign reachable_o     = res.reachable;
  assign distance_o      = res.distance;

endmodule

@@ bench/grid_bellman_ford_shortest_paths_test.sv @@
module grid_bellman_ford_shortest_paths_test;
  import gbf_pkg::*;

  localparam logic [1:0] REQ_IGNORED = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 20000000;
  localparam int unsigned SETTLE_CYCLES = 30;
  localparam int unsigned RANDOM_ITEMS = 950;

  typedef struct {
    bit          is_cfg;
    logic [2:0]  cfg_idx;
    logic [4:0]  cfg_val;
    logic [1:0]  req;
    logic [3:0]  fx, fy, fz, tx, ty, tz;
    logic [31:0] weight;
    bit          typed;
    res_t        answer;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic push = 1'b0;
  logic full;
  logic [1:0] req_type = '0;
  logic [3:0] from_x = '0, from_y = '0, from_z = '0;
  logic [3:0] to_x = '0, to_y = '0, to_z = '0;
  logic signed [31:0] edge_weight = '0;
  logic empty;
  logic pop = 1'b0;
  logic result_kind;
  logic [31:0] relax_count;
  logic [11:0] passes_used;
  logic edges_dropped;
  logic reachable;
  logic signed [47:0] distance;

  // Shadow of the block: registers, edge list, distances.
  logic [4:0] reg_file [7];
  int unsigned edge_tail [$];
  int unsigned edge_head [$];
  longint edge_wt [$];
  longint dist_mem [4096];
  bit reach_mem [4096];
  bit drop_seen;
  logic [31:0] last_relax;

  res_t pending_answers [$];
  plan_row_t plan [$];
  int errors = 0;
  int unsigned cycles = 0;
  int unsigned n_loads = 0, n_runs = 0, n_queries = 0, n_drops = 0, n_cfg = 0;
  bit idling_on = 1'b1;
  bit hold_request = 1'b0;
  int unsigned hold_left = 0;
  int unsigned pop_gap = 0;

  always #5 clk = ~clk;

  grid_bellman_ford_shortest_paths i_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .push           (push),
    .full           (full),
    .req_type_i     (req_type),
    .from_x_i       (from_x),
    .from_y_i       (from_y),
    .from_z_i       (from_z),
    .to_x_i         (to_x),
    .to_y_i         (to_y),
    .to_z_i         (to_z),
    .edge_weight_i  (edge_weight),
    .empty          (empty),
    .pop            (pop),
    .result_kind_o  (result_kind),
    .relax_count_o  (relax_count),
    .passes_used_o  (passes_used),
    .edges_dropped_o(edges_dropped),
    .reachable_o    (reachable),
    .distance_o     (distance)
  );

  function automatic int unsigned clamp_extent(logic [4:0] v);
    if (v == 0) return 1;
    if (v > 16) return 16;
    return v;
  endfunction

  function automatic int unsigned ext_x();
    return clamp_extent(reg_file[CFG_SIZE_X]);
  endfunction

  function automatic int unsigned ext_y();
    return clamp_extent(reg_file[CFG_SIZE_Y]);
  endfunction

  function automatic int unsigned ext_z();
    return reg_file[CFG_MODE_3D][0] ? clamp_extent(reg_file[CFG_SIZE_Z]) : 1;
  endfunction

  function automatic bit grid_slot(logic [3:0] x, logic [3:0] y, logic [3:0] z,
                                   output int unsigned idx);
    int unsigned zz;
    zz = reg_file[CFG_MODE_3D][0] ? z : 0;
    idx = 0;
    if (x >= ext_x() || y >= ext_y() || zz >= ext_z()) return 1'b0;
    idx = x + ext_x() * (y + ext_y() * zz);
    return idx < 4096;
  endfunction

  function automatic longint clip48(longint v);
    longint hi, lo;
    hi = (longint'(1) <<< 47) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  function automatic res_t make_answer(logic kind, logic [31:0] rc, logic [11:0] pu,
                                       logic dr, logic rh, logic [47:0] dval);
    res_t r;
    r.kind = kind;
    r.relax_count = rc;
    r.passes_used = pu;
    r.edges_dropped = dr;
    r.reachable = rh;
    r.distance = dval;
    return r;
  endfunction

  // Bellman-Ford over the shadow edge list; later edges see updates at once.
  function automatic res_t shortest_paths_run();
    int unsigned verts, limit, pass, src;
    int unsigned t, h;
    logic [31:0] relax;
    bit changed;
    longint nd;
    res_t r;
    verts = ext_x() * ext_y() * ext_z();
    if (verts > 4096) verts = 4096;
    limit = verts - 1;
    pass = 0;
    relax = 0;
    changed = 1'b1;
    foreach (reach_mem[i]) reach_mem[i] = 1'b0;
    if (grid_slot(reg_file[CFG_ORIGIN_X][3:0], reg_file[CFG_ORIGIN_Y][3:0],
                  reg_file[CFG_ORIGIN_Z][3:0], src)) begin
      reach_mem[src] = 1'b1;
      dist_mem[src] = 0;
    end
    while (pass < limit && changed) begin
      changed = 1'b0;
      pass++;
      foreach (edge_tail[j]) begin
        t = edge_tail[j];
        h = edge_head[j];
        if (reach_mem[t]) begin
          nd = clip48(dist_mem[t] + edge_wt[j]);
          if (!reach_mem[h] || nd < dist_mem[h]) begin
            dist_mem[h] = nd;
            reach_mem[h] = 1'b1;
            changed = 1'b1;
            if (relax != 32'hFFFF_FFFF) relax++;
          end
        end
      end
    end
    last_relax = relax;
    r = make_answer(RK_RUN, relax, pass > 4095 ? 12'd4095 : pass[11:0], drop_seen, 1'b0, '0);
    edge_tail.delete();
    edge_head.delete();
    edge_wt.delete();
    drop_seen = 1'b0;
    return r;
  endfunction

  // Applies one accepted request to the shadow; returns 1 when it yields an answer.
  function automatic bit predict_request(plan_row_t p, output res_t r);
    int unsigned a, b;
    r = make_answer(1'b0, '0, '0, 1'b0, 1'b0, '0);
    case (p.req)
      REQ_LOAD: begin
        n_loads++;
        if (grid_slot(p.fx, p.fy, p.fz, a) && grid_slot(p.tx, p.ty, p.tz, b) &&
            edge_tail.size() < 16384) begin
          edge_tail.insert(edge_tail.size(), a);
          edge_head.insert(edge_head.size(), b);
          edge_wt.insert(edge_wt.size(), longint'($signed(p.weight)));
        end else begin
          drop_seen = 1'b1;
          n_drops++;
        end
        return 1'b0;
      end
      REQ_RUN: begin
        n_runs++;
        r = shortest_paths_run();
        return 1'b1;
      end
      REQ_QUERY: begin
        n_queries++;
        r = make_answer(RK_QUERY, last_relax, '0, drop_seen, 1'b0, '0);
        if (grid_slot(p.fx, p.fy, p.fz, a) && reach_mem[a]) begin
          r.reachable = 1'b1;
          r.distance = dist_mem[a][47:0];
        end
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic plan_row_t req_row(logic [1:0] req, logic [3:0] fx, logic [3:0] fy,
                                        logic [3:0] fz, logic [3:0] tx, logic [3:0] ty,
                                        logic [3:0] tz, logic [31:0] w);
    plan_row_t p;
    p = '{default: '0};
    p.req = req;
    p.fx = fx; p.fy = fy; p.fz = fz;
    p.tx = tx; p.ty = ty; p.tz = tz;
    p.weight = w;
    return p;
  endfunction

  function automatic plan_row_t cfg_row(logic [2:0] idx, logic [4:0] val);
    plan_row_t p;
    p = '{default: '0};
    p.is_cfg = 1'b1;
    p.cfg_idx = idx;
    p.cfg_val = val;
    return p;
  endfunction

  function automatic plan_row_t typed_row(plan_row_t p, res_t r);
    p.typed = 1'b1;
    p.answer = r;
    return p;
  endfunction

  function automatic void add_row(plan_row_t p);
    plan.insert(plan.size(), p);
  endfunction

  task automatic wait_quiet();
    while (pending_answers.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_register(logic [2:0] idx, logic [4:0] val);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    do @(posedge clk); while (!cfg_ready);
    reg_file[idx] = (idx >= CFG_ORIGIN_X) ? (val & 5'd15) : (idx == CFG_MODE_3D ? val & 5'd1 : val);
    n_cfg++;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic offer_request(plan_row_t p);
    res_t r;
    if (idling_on && $urandom_range(0, 3) == 0) begin
      push = 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    req_type = p.req;
    from_x = p.fx; from_y = p.fy; from_z = p.fz;
    to_x = p.tx; to_y = p.ty; to_z = p.tz;
    edge_weight = p.weight;
    push = 1'b1;
    do @(posedge clk); while (full);
    if (predict_request(p, r))
      pending_answers.insert(pending_answers.size(), p.typed ? p.answer : r);
    @(negedge clk);
    push = 1'b0;
  endtask

  task automatic apply_row(plan_row_t p);
    if (p.is_cfg) begin
      wait_quiet();
      write_register(p.cfg_idx, p.cfg_val);
    end else begin
      offer_request(p);
    end
  endtask

  function automatic logic [3:0] pick_coord(int unsigned ext);
    if ($urandom_range(0, 7) == 0) return 4'($urandom_range(0, 15));
    return 4'($urandom_range(0, ext - 1));
  endfunction

  function automatic logic [31:0] pick_weight();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return 32'h7FFF_FFFF;
      2: return 32'h8000_0000;
      default: return 32'($signed($urandom_range(0, 2000)) - 500) <<< 16;
    endcase
  endfunction

  function automatic logic [4:0] pick_size(bit wide);
    case ($urandom_range(0, 9))
      0: return 5'd0;
      1: return wide ? 5'd16 : 5'd1;
      2: return wide ? 5'd31 : 5'd4;
      default: return 5'($urandom_range(1, 4));
    endcase
  endfunction

  task automatic random_phase(int unsigned phase_no);
    bit three_d, wide;
    int unsigned n_edges;
    wide = ($urandom_range(0, 7) == 0);
    three_d = !wide && $urandom_range(0, 2) == 0;
    if (phase_no == 0 || $urandom_range(0, 2) == 0) begin
      wait_quiet();
      write_register(CFG_SIZE_X, pick_size(wide));
      write_register(CFG_SIZE_Y, pick_size(wide));
      write_register(CFG_SIZE_Z, three_d ? pick_size(1'b0) : 5'($urandom_range(0, 31)));
      write_register(CFG_MODE_3D, 5'(three_d));
      write_register(CFG_ORIGIN_X,
                     $urandom_range(0, 7) == 0 ? 5'd15 : 5'($urandom_range(0, 3)));
      write_register(CFG_ORIGIN_Y,
                     $urandom_range(0, 7) == 0 ? 5'd15 : 5'($urandom_range(0, 3)));
      write_register(CFG_ORIGIN_Z, 5'($urandom_range(0, 3)));
    end
    if ($urandom_range(0, 5) == 0)
      offer_request(req_row(REQ_QUERY, pick_coord(ext_x()), pick_coord(ext_y()),
                            pick_coord(ext_z()), 4'($urandom), 4'($urandom), 4'($urandom),
                            $urandom));
    n_edges = $urandom_range(0, 10);
    repeat (n_edges) begin
      offer_request(req_row(REQ_LOAD, pick_coord(ext_x()), pick_coord(ext_y()),
                            pick_coord(ext_z()), pick_coord(ext_x()), pick_coord(ext_y()),
                            pick_coord(ext_z()), pick_weight()));
      if ($urandom_range(0, 15) == 0)
        offer_request(req_row(REQ_IGNORED, 4'($urandom), 4'($urandom), 4'($urandom),
                              4'($urandom), 4'($urandom), 4'($urandom), $urandom));
    end
    if ($urandom_range(0, 9) != 0)
      offer_request(req_row(REQ_RUN, 4'($urandom), 4'($urandom), 4'($urandom),
                            4'($urandom), 4'($urandom), 4'($urandom), $urandom));
    repeat ($urandom_range(1, 6))
      offer_request(req_row(REQ_QUERY, pick_coord(ext_x()), pick_coord(ext_y()),
                            pick_coord(ext_z()), 4'($urandom), 4'($urandom), 4'($urandom),
                            $urandom));
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d answers outstanding", $time, cycles,
               pending_answers.size());
      $display("grid_bellman_ford_shortest_paths_test: FAIL");
      $finish;
    end
  end

  // Result side: random pop gaps, plus one long hold-off on request.
  initial begin
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        pop = 1'b0;
      end else if (hold_request) begin
        hold_request = 1'b0;
        hold_left = 300;
        pop = 1'b0;
      end else if (pop_gap > 0) begin
        pop_gap--;
        pop = 1'b0;
      end else if (idling_on && $urandom_range(0, 3) == 0) begin
        pop_gap = $urandom_range(0, 2);
        pop = 1'b0;
      end else begin
        pop = 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    res_t want;
    if (rst_n && pop && !empty) begin
      if (pending_answers.size() == 0) begin
        $display("%0t: unexpected result kind=%0d relax=%0d", $time, result_kind, relax_count);
        errors++;
      end else begin
        want = pending_answers.pop_front();
        if (result_kind !== want.kind) begin
          $display("%0t: result_kind expected %0d actual %0d", $time, want.kind, result_kind);
          errors++;
        end
        if (relax_count !== want.relax_count) begin
          $display("%0t: relax_count expected %0d actual %0d", $time, want.relax_count,
                   relax_count);
          errors++;
        end
        if (passes_used !== want.passes_used) begin
          $display("%0t: passes_used expected %0d actual %0d", $time, want.passes_used,
                   passes_used);
          errors++;
        end
        if (edges_dropped !== want.edges_dropped) begin
          $display("%0t: edges_dropped expected %0d actual %0d", $time, want.edges_dropped,
                   edges_dropped);
          errors++;
        end
        if (reachable !== want.reachable) begin
          $display("%0t: reachable expected %0d actual %0d", $time, want.reachable, reachable);
          errors++;
        end
        if (distance !== want.distance) begin
          $display("%0t: distance expected %0d actual %0d", $time,
                   $signed(want.distance), distance);
          errors++;
        end
      end
    end
  end

  initial begin
    res_t zero_query;
    int unsigned sent;
    int unsigned phase_no;
    foreach (reg_file[i]) reg_file[i] = 5'd0;
    reg_file[CFG_SIZE_X] = 5'd16;
    reg_file[CFG_SIZE_Y] = 5'd16;
    reg_file[CFG_SIZE_Z] = 5'd1;
    drop_seen = 1'b0;
    last_relax = '0;
    foreach (reach_mem[i]) reach_mem[i] = 1'b0;
    zero_query = make_answer(RK_QUERY, '0, '0, 1'b0, 1'b0, '0);

    // Reset-state answers, then a max/min weight chain on the default grid.
    add_row(typed_row(req_row(REQ_QUERY, 0, 0, 0, 0, 0, 0, 0), zero_query));
    add_row(typed_row(req_row(REQ_RUN, 0, 0, 0, 0, 0, 0, 0),
                      make_answer(RK_RUN, '0, 12'd1, 1'b0, 1'b0, '0)));
    add_row(req_row(REQ_IGNORED, 15, 15, 15, 15, 15, 15, 32'hFFFF_FFFF));
    add_row(req_row(REQ_LOAD, 0, 0, 0, 1, 0, 0, 32'h7FFF_FFFF));
    add_row(req_row(REQ_LOAD, 1, 0, 0, 2, 0, 0, 32'h7FFF_FFFF));
    add_row(req_row(REQ_LOAD, 2, 0, 0, 3, 0, 0, 32'h8000_0000));
    add_row(req_row(REQ_LOAD, 15, 15, 15, 0, 0, 9, 32'h0));
    add_row(req_row(REQ_RUN, 0, 0, 0, 0, 0, 0, 0));
    add_row(req_row(REQ_QUERY, 3, 0, 0, 0, 0, 0, 0));
    add_row(req_row(REQ_QUERY, 2, 0, 7, 0, 0, 0, 0));
    add_row(req_row(REQ_QUERY, 5, 5, 0, 0, 0, 0, 0));
    // A two-by-one grid: an edge off the grid is dropped.
    add_row(cfg_row(CFG_SIZE_X, 5'd2));
    add_row(cfg_row(CFG_SIZE_Y, 5'd0));
    add_row(req_row(REQ_LOAD, 2, 0, 0, 0, 0, 0, 32'h1));
    add_row(typed_row(req_row(REQ_RUN, 0, 0, 0, 0, 0, 0, 0),
                      make_answer(RK_RUN, '0, 12'd1, 1'b1, 1'b0, '0)));
    add_row(req_row(REQ_QUERY, 2, 0, 0, 0, 0, 0, 0));
    // Negative cycle between the two vertices.
    add_row(req_row(REQ_LOAD, 0, 0, 0, 1, 0, 0, 32'hFFFF_FFFF));
    add_row(req_row(REQ_LOAD, 1, 0, 0, 0, 0, 0, 32'h8000_0000));
    add_row(req_row(REQ_RUN, 0, 0, 0, 0, 0, 0, 0));
    add_row(req_row(REQ_QUERY, 0, 0, 0, 0, 0, 0, 0));
    // Single-vertex grid makes no pass at all.
    add_row(cfg_row(CFG_SIZE_X, 5'd1));
    add_row(typed_row(req_row(REQ_RUN, 0, 0, 0, 0, 0, 0, 0),
                      make_answer(RK_RUN, '0, 12'd0, 1'b0, 1'b0, '0)));
    // Full 3D grid with the source in the far corner and a negative cycle.
    add_row(cfg_row(CFG_SIZE_X, 5'd31));
    add_row(cfg_row(CFG_SIZE_Y, 5'd16));
    add_row(cfg_row(CFG_SIZE_Z, 5'd16));
    add_row(cfg_row(CFG_MODE_3D, 5'd1));
    add_row(cfg_row(CFG_ORIGIN_X, 5'd15));
    add_row(cfg_row(CFG_ORIGIN_Y, 5'd15));
    add_row(cfg_row(CFG_ORIGIN_Z, 5'd15));
    add_row(req_row(REQ_LOAD, 15, 15, 15, 0, 0, 0, 32'hFFFB_0000));
    add_row(req_row(REQ_LOAD, 0, 0, 0, 15, 15, 15, 32'h0003_0000));
    add_row(req_row(REQ_RUN, 0, 0, 0, 0, 0, 0, 0));
    add_row(req_row(REQ_QUERY, 0, 0, 0, 0, 0, 0, 0));
    add_row(req_row(REQ_QUERY, 15, 15, 15, 0, 0, 0, 0));
    // Source off the grid: nothing becomes reachable.
    add_row(cfg_row(CFG_SIZE_X, 5'd4));
    add_row(cfg_row(CFG_MODE_3D, 5'd0));
    add_row(req_row(REQ_LOAD, 0, 0, 0, 1, 1, 0, 32'h0001_0000));
    add_row(req_row(REQ_RUN, 0, 0, 0, 0, 0, 0, 0));
    add_row(req_row(REQ_QUERY, 1, 1, 0, 0, 0, 0, 0));

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (plan[i]) apply_row(plan[i]);

    phase_no = 0;
    sent = n_loads + n_runs + n_queries;
    while (n_loads + n_runs + n_queries - sent < RANDOM_ITEMS) begin
      if (n_loads + n_runs + n_queries - sent > RANDOM_ITEMS * 85 / 100) idling_on = 1'b0;
      if (phase_no == 20) begin
        // Long hold on the result side while queries keep coming.
        hold_request = 1'b1;
        repeat (16) offer_request(req_row(REQ_QUERY, 4'($urandom), 4'($urandom),
                                          4'($urandom), 0, 0, 0, 0));
      end
      random_phase(phase_no);
      phase_no++;
    end

    while (pending_answers.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    $display("Covered %0d edge loads (%0d dropped), %0d runs, %0d queries, %0d register writes.",
             n_loads, n_drops, n_runs, n_queries, n_cfg);
    if (errors == 0) begin
      $display("grid_bellman_ford_shortest_paths_test: PASS");
    end else begin
      $display("%0d mismatches found.", errors);
      $display("grid_bellman_ford_shortest_paths_test: FAIL");
    end
    $finish;
  end

endmodule

@@ grid_bellman_ford_shortest_paths.f @@
hdl/gbf_pkg.sv
hdl/gbf_ram.sv
hdl/gbf_fifo.sv
hdl/gbf_front.sv
hdl/gbf_back.sv
hdl/grid_bellman_ford_shortest_paths.sv
bench/grid_bellman_ford_shortest_paths_test.sv
